// File: sv/arpc_pkg.sv
package arpc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_LEARN  = 3'd0,
        OP_STATIC = 3'd1,
        OP_DELETE = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_TICK   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_MAC  = 2'd3
    } t_status;

    // One classified command handed from the front end to the table engine.
    typedef struct packed {
        logic [2:0]  op;
        logic        zero_mac;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] ttl;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] mac;
        logic [15:0] ttl;
    } t_result;

endpackage

// File: sv/arpc_front.sv
module arpc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_op,
    input  logic [31:0]           i_ip,
    input  logic [47:0]           i_mac,
    input  logic [15:0]           i_ttl,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output arpc_pkg::t_cmd        o_cmd
);
    import arpc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             push, pop;
    t_cmd             cmd;

    always_comb begin
        cmd.op       = i_op;
        cmd.zero_mac = (i_mac == 48'd0);
        cmd.ip       = i_ip;
        cmd.mac      = i_mac;
        cmd.ttl      = i_ttl;
    end

    assign o_ready     = (r_cnt != (PTR_W+1)'(FIFO_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(FIFO_DEPTH)) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("queue push lost");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop from empty queue");
`endif

endmodule

// File: sv/arpc_engine.sv
module arpc_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  arpc_pkg::t_cmd        i_cmd,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output arpc_pkg::t_result     o_res
);
    import arpc_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_ip  [TABLE_ENTRIES];
    logic [47:0]              r_mac [TABLE_ENTRIES];
    logic [15:0]              r_ttl [TABLE_ENTRIES];
    logic [15:0]              r_dttl;

    // Match stage registers.
    logic                     r_s1;
    t_cmd                     r_cmd;
    logic [TABLE_ENTRIES-1:0] r_hit;
    logic [TABLE_ENTRIES-1:0] r_free;
    logic                     r_busy;

    logic                     r_out_v;
    t_result                  r_out;

    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic                     take;
    logic                     any_hit, any_free;
    logic [IDX_W-1:0]         hit_idx, free_idx;
    t_result                  res;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_ip[i] == i_cmd.ip);
        end
    end

    // One command in flight: accept only when nothing is pending or waiting.
    assign o_cmd_ready = !r_busy && !r_out_v;
    assign take        = i_cmd_valid && o_cmd_ready;

    always_comb begin
        any_hit  = 1'b0;
        hit_idx  = '0;
        any_free = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES-1; i >= 0; i--) begin
            if (r_hit[i]) begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (r_free[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        res.status = ST_OK;
        res.mac    = '0;
        res.ttl    = '0;
        case (r_cmd.op)
            OP_LEARN: begin
                if (r_cmd.zero_mac)          res.status = ST_ZERO_MAC;
                else if (!any_hit && !any_free) res.status = ST_FULL;
            end
            OP_STATIC: begin
                if (!any_hit && !any_free) res.status = ST_FULL;
            end
            OP_DELETE: begin
                if (!any_hit) res.status = ST_NOT_FOUND;
            end
            OP_LOOKUP: begin
                if (any_hit) begin
                    res.mac = r_mac[hit_idx];
                    res.ttl = r_ttl[hit_idx];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd  <= i_cmd;
            r_hit  <= hit_vec;
            r_free <= ~r_valid;
        end
        if (r_s1) begin
            r_out <= res;
            case (r_cmd.op)
                OP_LEARN, OP_STATIC: begin
                    if (!(r_cmd.op == OP_LEARN && r_cmd.zero_mac)) begin
                        if (any_hit) begin
                            r_mac[hit_idx] <= r_cmd.mac;
                            if (r_cmd.op == OP_STATIC) r_ttl[hit_idx] <= r_cmd.ttl;
                        end else if (any_free) begin
                            r_ip[free_idx]  <= r_cmd.ip;
                            r_mac[free_idx] <= r_cmd.mac;
                            r_ttl[free_idx] <= (r_cmd.op == OP_STATIC) ? r_cmd.ttl : r_dttl;
                        end
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (r_valid[i] && r_ttl[i] != 16'd0) r_ttl[i] <= r_ttl[i] - 16'd1;
                    end
                end
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dttl  <= 16'd60;
            r_s1    <= 1'b0;
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) r_dttl <= i_cfg_data;
            r_s1 <= take;
            if (take) r_busy <= 1'b1;
            else if (r_s1) r_busy <= 1'b0;
            if (r_s1) r_out_v <= 1'b1;
            else if (i_res_ready) r_out_v <= 1'b0;
            if (r_s1) begin
                case (r_cmd.op)
                    OP_LEARN, OP_STATIC: begin
                        if (!(r_cmd.op == OP_LEARN && r_cmd.zero_mac) && !any_hit
                                && any_free) begin
                            r_valid[free_idx] <= 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (any_hit) r_valid[hit_idx] <= 1'b0;
                    end
                    OP_TICK: begin
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (r_ttl[i] <= 16'd1) r_valid[i] <= 1'b0;
                        end
                    end
                    OP_CLEAR: r_valid <= '0;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1 |-> $onehot0(r_hit)) else $error("duplicate address in table");
    a_s1_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1 |-> r_busy) else $error("match stage without busy");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !take) else $error("command accepted while busy");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1 && r_cmd.op == OP_CLEAR) |=> r_valid == '0) else $error("clear failed");
`endif

endmodule

// File: sv/arp_cache_with_ttl_aging.sv
// ARP cache of 16 IPv4-to-MAC entries with per-entry lifetime in ticks. Each
// input beat carries one operation (learned add, static add, delete, lookup,
// tick, clear) and yields exactly one output beat with a status and, on a
// lookup hit, the stored MAC and remaining TTL. A front end queues up to two
// beats and hands them to the table engine one at a time. The engine compares
// the address against all entries in the cycle that it takes a beat,
// commits the update and registers the result in the next cycle, and presents
// the result beat in the cycle after that. The engine holds one operation at a
// time and takes no new beat until its result beat has been accepted. Learned
// adds with an all-zero MAC are ignored, and a new entry with no free slot is
// refused with a table-full status. default_ttl resets to 60; the user must
// write it through i_cfg_we only while the block is idle, which the block
// itself does not enforce.
module arp_cache_with_ttl_aging (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], ip_address[34:3], mac_address[82:35], ttl_value[98:83], zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], found_mac[49:2], found_ttl[65:50], zero pad
    output logic [71:0]  m_axis_tdata
);
    import arpc_pkg::*;

    t_cmd    cmd;
    logic    cmd_valid, cmd_ready;
    t_result res;

    arpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tdata[2:0]),
        .i_ip        (s_axis_tdata[34:3]),
        .i_mac       (s_axis_tdata[82:35]),
        .i_ttl       (s_axis_tdata[98:83]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    arpc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {6'd0, res.ttl, res.mac, res.status};

endmodule
